// File: rtl/core/dghm_pkg.sv
// Package: shared constants and types of the depth-to-gray mapper.
package dghm_pkg;
   localparam int unsigned DEPTH_LEVELS_DEF = 16384;
   localparam int unsigned MAX_FRAME_PIXELS_DEF = 524288;
   localparam int unsigned DEPTH_W = 16;
   localparam int unsigned BP_W = 14;
   localparam int unsigned CNT_W = 20;
   localparam int unsigned GRAY_W = 8;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 14;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HISTOGRAM_MODE = 1'b0,
      CSR_BACKPLANE      = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_COUNT = 2'd0,
      OP_MAP   = 2'd1,
      OP_SKIP  = 2'd2
   } op_type;

   // One classified transaction as it travels from front to back.
   typedef struct packed {
      op_type              op;
      logic [DEPTH_W-1:0]  depth;
      logic                in_range;
      logic                last;
      logic                hist_mode;
      logic [BP_W-1:0]     backplane;
   } cmd_type;
endpackage

// File: rtl/core/dghm_stream_if.sv
// Interface: valid/ready channel with a generic payload.
interface dghm_stream_if #(
   parameter int unsigned DATA_W = 8
) ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/dghm_front.sv
// Front end: accept pixels, classify them and queue commands for the back end.
module dghm_front
   import dghm_pkg::*;
#(
   parameter int unsigned DEPTH_LEVELS = DEPTH_LEVELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [DEPTH_W-1:0] req_depth,
   input  logic             req_last,
   input  logic             hist_mode,
   input  logic [BP_W-1:0]  backplane,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cmd_type          cmd_data
);
   localparam int unsigned QA_W = $clog2(QUEUE_DEPTH);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]   wptr_ff, rptr_ff;
   logic [QA_W:0]     fill_ff;
   logic              push, pop;
   cmd_type           cmd_in;
   logic [16:0]       levels;

   assign levels = 17'(DEPTH_LEVELS);
   assign req_ready = (fill_ff != (QA_W+1)'(QUEUE_DEPTH));
   assign push = req_valid && req_ready;
   assign cmd_valid = (fill_ff != '0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd_data = queue_ff[rptr_ff];

   always_comb begin
      cmd_in.depth = req_depth;
      cmd_in.last = req_last;
      cmd_in.hist_mode = hist_mode;
      cmd_in.backplane = backplane;
      cmd_in.in_range = (req_depth != '0) && (req_depth <= {2'b0, backplane})
         && ({1'b0, req_depth} < levels);
      if (req_func) begin
         cmd_in.op = OP_MAP;
      end else if (hist_mode) begin
         cmd_in.op = OP_COUNT;
      end else begin
         cmd_in.op = OP_SKIP;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop) rptr_ff <= rptr_ff + 1'b1;
         fill_ff <= fill_ff + (QA_W+1)'(push) - (QA_W+1)'(pop);
      end
   end
endmodule

// File: rtl/core/dghm_divider.sv
// Divider: restoring radix-2 division of a 29-bit dividend by a 20-bit divisor.
module dghm_divider
   import dghm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [28:0]       dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [28:0]       quotient
);
   logic [28:0]      quot_ff;
   logic [CNT_W:0]   rem_ff;
   logic [CNT_W-1:0] dsr_ff;
   logic [4:0]       cnt_ff;
   logic             busy_ff, done_ff;
   logic [CNT_W:0]   trial;
   logic [CNT_W+1:0] diff;

   assign trial = {rem_ff[CNT_W-1:0], quot_ff[28]};
   assign diff = {1'b0, trial} - {2'b0, dsr_ff};
   assign done = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[CNT_W+1]) begin
            rem_ff <= diff[CNT_W:0];
            quot_ff <= {quot_ff[27:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quot_ff <= {quot_ff[27:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 5'd28;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

// File: rtl/core/dghm_back.sv
// Back end: histogram memory, normalization walk, clearing walk and gray mapping.
module dghm_back
   import dghm_pkg::*;
#(
   parameter int unsigned DEPTH_LEVELS     = DEPTH_LEVELS_DEF,
   parameter int unsigned MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [GRAY_W-1:0] rsp_brightness,
   output logic              rsp_last_res
);
   localparam int unsigned AW = $clog2(DEPTH_LEVELS);
   localparam logic [CNT_W-1:0] CAP = (MAX_FRAME_PIXELS < 1048575)
      ? CNT_W'(MAX_FRAME_PIXELS) : {CNT_W{1'b1}};
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH_LEVELS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_MAP_RD, ST_MAP_DIV, ST_MAP_OUT,
      ST_NRM_RD, ST_NRM_DIV, ST_NRM_WR, ST_OUT
   } state_type;

   logic [CNT_W-1:0] mem [DEPTH_LEVELS];
   logic [CNT_W-1:0] rd_ff;
   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [CNT_W-1:0] wr_data;

   state_type        state_ff;
   cmd_type          cmd_ff;
   logic [AW-1:0]    addr_ff;
   logic [CNT_W-1:0] npts_ff;
   logic [CNT_W:0]   cum_ff;
   logic             norm_ff;
   logic             clr_after_ff;
   logic [GRAY_W-1:0] gray_ff;
   logic             last_ff;
   logic             rsp_valid_ff;

   logic             div_start, div_done;
   logic [28:0]      div_dividend, div_q;
   logic [CNT_W-1:0] div_divisor;
   logic [CNT_W:0]   cum_sum, cum_sat;
   logic [BP_W-1:0]  lin_num;

   dghm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (rd_en) rd_ff <= mem[rd_addr];
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   assign cum_sum = cum_ff + {1'b0, rd_ff};
   assign cum_sat = (cum_sum > {1'b0, npts_ff}) ? {1'b0, npts_ff} : cum_sum;
   assign lin_num = cmd_ff.backplane - cmd_ff.depth[BP_W-1:0];

   always_comb begin
      rd_en = 1'b0;
      rd_addr = addr_ff;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      div_start = 1'b0;
      div_dividend = '0;
      div_divisor = npts_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            rd_en = 1'b1;
            rd_addr = cmd_data.depth[AW-1:0];
         end
         ST_CNT_RD: begin
            rd_en = 1'b1;
            rd_addr = cmd_ff.depth[AW-1:0];
         end
         ST_CNT_WR: begin
            wr_en = cmd_ff.in_range && (rd_ff < CAP);
            wr_addr = cmd_ff.depth[AW-1:0];
            wr_data = rd_ff + 1'b1;
         end
         ST_NRM_RD: begin
            rd_en = 1'b1;
         end
         ST_NRM_DIV: begin
            div_start = (addr_ff != '0) && (npts_ff != '0);
            div_dividend = {cum_sat[CNT_W-1:0] ^ cum_sat[CNT_W-1:0], 9'b0}
               | 29'({npts_ff - cum_sat[CNT_W-1:0], 8'b0});
         end
         ST_NRM_WR: begin
            wr_en = (addr_ff != '0);
            wr_data = (npts_ff == '0)
               ? ((cum_ff > 21'hFFFFF) ? {CNT_W{1'b1}} : cum_ff[CNT_W-1:0])
               : div_q[CNT_W-1:0];
         end
         ST_MAP_RD: begin
            div_start = !cmd_ff.hist_mode && (cmd_ff.depth != '0)
               && (cmd_ff.backplane != '0)
               && (cmd_ff.depth < {2'b0, cmd_ff.backplane});
            div_dividend = 29'({lin_num, 8'b0}) - 29'(lin_num);
            div_divisor = CNT_W'(cmd_ff.backplane);
         end
         default: ;
      endcase
   end

   assign cmd_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_brightness = gray_ff;
   assign rsp_last_res = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         npts_ff <= '0;
         cum_ff <= '0;
         norm_ff <= 1'b0;
         clr_after_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gray_ff <= '0;
         last_ff <= 1'b0;
         cmd_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == LAST_ADDR) begin
                  addr_ff <= '0;
                  if (clr_after_ff) begin
                     clr_after_ff <= 1'b0;
                     state_ff <= ST_CNT_RD;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  cmd_ff <= cmd_data;
                  case (cmd_data.op)
                     OP_COUNT: begin
                        if (norm_ff) begin
                           norm_ff <= 1'b0;
                           npts_ff <= '0;
                           clr_after_ff <= 1'b1;
                           addr_ff <= '0;
                           state_ff <= ST_CLEAR;
                        end else begin
                           state_ff <= ST_CNT_RD;
                        end
                     end
                     OP_MAP: state_ff <= ST_MAP_RD;
                     default: ;
                  endcase
               end
            end
            ST_CNT_RD: begin
               state_ff <= ST_CNT_WR;
            end
            ST_CNT_WR: begin
               if (cmd_ff.in_range && (npts_ff < CAP)) npts_ff <= npts_ff + 1'b1;
               if (cmd_ff.last) begin
                  addr_ff <= '0;
                  cum_ff <= '0;
                  state_ff <= ST_NRM_RD;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_NRM_RD: state_ff <= ST_NRM_DIV;
            ST_NRM_DIV: begin
               cum_ff <= cum_sat;
               if ((addr_ff != '0) && (npts_ff != '0)) begin
                  state_ff <= ST_NRM_WR;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               state_ff <= ST_NRM_WR;
            end
            ST_NRM_WR: begin
               if ((addr_ff == '0) || (npts_ff == '0) || div_done) begin
                  if (addr_ff == LAST_ADDR) begin
                     addr_ff <= '0;
                     norm_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     addr_ff <= addr_ff + 1'b1;
                     state_ff <= ST_NRM_RD;
                  end
               end
            end
            ST_MAP_RD: begin
               if (cmd_ff.hist_mode) begin
                  gray_ff <= (norm_ff && cmd_ff.in_range)
                     ? ((rd_ff > 20'd255) ? 8'hFF : rd_ff[GRAY_W-1:0]) : '0;
                  state_ff <= ST_MAP_OUT;
               end else if (div_start) begin
                  state_ff <= ST_MAP_DIV;
               end else begin
                  gray_ff <= '0;
                  state_ff <= ST_MAP_OUT;
               end
            end
            ST_MAP_DIV: begin
               if (div_done) begin
                  gray_ff <= div_q[GRAY_W-1:0];
                  state_ff <= ST_MAP_OUT;
               end
            end
            ST_MAP_OUT: begin
               rsp_valid_ff <= 1'b1;
               last_ff <= cmd_ff.last;
               if (cmd_ff.last) begin
                  norm_ff <= 1'b0;
                  npts_ff <= '0;
                  addr_ff <= '0;
                  state_ff <= ST_CLEAR;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: rtl/core/depth_to_gray_histogram_map.sv
// A histogram-mode pixel reads its bin; a linear-mode pixel waits on the serial divider.
// The back end takes one command at a time; the serial divider sets the pace in linear mode.
// A gathering pass that ends runs a normalization walk over every bin.
// The last mapping pixel, and a gathering pixel after normalization, start a clear walk
// over all DEPTH_LEVELS bins. Reset is synchronous and starts the same clear walk.
module depth_to_gray_histogram_map
   import dghm_pkg::*;
#(
   parameter int unsigned DEPTH_LEVELS     = DEPTH_LEVELS_DEF,
   parameter int unsigned MAX_FRAME_PIXELS = MAX_FRAME_PIXELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   dghm_stream_if.sink           req,
   dghm_stream_if.source         rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic            hist_mode_ff;
   logic [BP_W-1:0] backplane_ff;
   logic            cmd_valid, cmd_ready;
   cmd_type         cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_mode_ff <= 1'b0;
         backplane_ff <= BP_W'(4000);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HISTOGRAM_MODE: hist_mode_ff <= csr_wdata[0];
            CSR_BACKPLANE:      backplane_ff <= csr_wdata[BP_W-1:0];
            default: ;
         endcase
      end
   end

   dghm_front #(.DEPTH_LEVELS(DEPTH_LEVELS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_func  (req.data[0]),
      .req_depth (req.data[16:1]),
      .req_last  (req.data[17]),
      .hist_mode (hist_mode_ff),
      .backplane (backplane_ff),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   dghm_back #(
      .DEPTH_LEVELS    (DEPTH_LEVELS),
      .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd_data       (cmd_data),
      .rsp_valid      (rsp.valid),
      .rsp_ready      (rsp.ready),
      .rsp_brightness (rsp.data[7:0]),
      .rsp_last_res   (rsp.data[8])
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready && (cmd_data.op != OP_SKIP) |=> !cmd_ready)
      else $error("back end took two commands back to back");
   assert property (@(posedge clock) $past(reset) |-> !rsp.valid)
      else $error("result after reset");
endmodule

// File: tb/tb_depth_to_gray_histogram_map.sv
// Testbench: stream checker of depth_to_gray_histogram_map against a local gray-map predictor.
module tb_depth_to_gray_histogram_map;
   import dghm_pkg::*;

   localparam int unsigned LEVELS  = DEPTH_LEVELS_DEF;
   localparam int unsigned CNT_CAP = (MAX_FRAME_PIXELS_DEF < 20'hFFFFF) ?
                                     MAX_FRAME_PIXELS_DEF : 20'hFFFFF;
   localparam int unsigned REQ_W   = 1 + DEPTH_W + 1;
   localparam int unsigned RSP_W   = GRAY_W + 1;

   typedef struct packed {
      logic               last;
      logic [DEPTH_W-1:0] depth;
      logic               func;
   } pixel_type;

   typedef struct packed {
      logic              last_res;
      logic [GRAY_W-1:0] brightness;
   } gray_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dghm_stream_if #(.DATA_W(REQ_W)) req_if ();
   dghm_stream_if #(.DATA_W(RSP_W)) rsp_if ();

   depth_to_gray_histogram_map dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_type pixel_queue[$];
   gray_type  gray_queue[$];
   int        failures;
   int        idle_mode;
   logic      long_stall_req;
   int        stall_left;

   logic              mode_shadow;
   logic [BP_W-1:0]   bp_shadow;
   logic [CNT_W-1:0]  hist_bins [LEVELS];
   logic [CNT_W-1:0]  hist_points;
   logic              hist_ready;

   function automatic void clear_hist();
      foreach (hist_bins[i]) hist_bins[i] = '0;
      hist_points = '0;
      hist_ready  = 1'b0;
   endfunction

   function automatic void equalize_hist();
      logic [63:0] cum;
      logic [63:0] c;
      logic [63:0] n;
      cum = 0;
      n   = hist_points;
      for (int i = 0; i < LEVELS; i++) begin
         cum += hist_bins[i];
         if (i != 0) begin
            if (n == 0) begin
               hist_bins[i] = (cum > 64'hFFFFF) ? 20'hFFFFF : cum[CNT_W-1:0];
            end else begin
               c = (cum > n) ? n : cum;
               hist_bins[i] = CNT_W'((64'd256 * (n - c)) / n);
            end
         end
      end
      hist_ready = 1'b1;
   endfunction

   function automatic void predict_gray(pixel_type p);
      gray_type g;
      logic [31:0] v;
      g.brightness = '0;
      g.last_res   = p.last;
      if (p.func == 1'b0) begin
         if (mode_shadow) begin
            if (hist_ready) clear_hist();
            if (p.depth != 0 && p.depth <= bp_shadow && p.depth < LEVELS) begin
               if (hist_bins[p.depth] < CNT_CAP) hist_bins[p.depth]++;
               if (hist_points < CNT_CAP) hist_points++;
            end
            if (p.last) equalize_hist();
         end
      end else begin
         if (p.depth != 0) begin
            if (mode_shadow) begin
               if (hist_ready && p.depth <= bp_shadow && p.depth < LEVELS) begin
                  v = hist_bins[p.depth];
                  g.brightness = (v > 255) ? 8'd255 : v[GRAY_W-1:0];
               end
            end else if (bp_shadow != 0 && p.depth < bp_shadow) begin
               v = (32'd255 * (bp_shadow - p.depth)) / bp_shadow;
               g.brightness = v[GRAY_W-1:0];
            end
         end
         gray_queue.push_back(g);
         if (p.last) clear_hist();
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 20000000);
      $display("FAIL depth_to_gray_histogram_map");
      $finish;
   end

   // sender
   always @(posedge clock) begin
      int pct;
      logic take;
      pct  = (idle_mode == 0) ? 21 : (idle_mode == 1) ? 50 : 0;
      take = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data  <= '0;
      end else begin
         if (take) begin
            predict_gray(pixel_queue.pop_front());
         end
         if (req_if.valid && !take) begin
            req_if.valid <= 1'b1;
         end else if (pixel_queue.size() > 0 && $urandom_range(99) >= pct) begin
            req_if.valid <= 1'b1;
            req_if.data  <= pixel_queue[0];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      int pct;
      pct = (idle_mode == 0) ? 50 : (idle_mode == 1) ? 21 : 0;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (long_stall_req && stall_left == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 400;
      end else if (stall_left > 1) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= pct);
         if (stall_left == 1) stall_left <= -1;
      end
   end

   // result check
   always @(posedge clock) begin
      gray_type got;
      gray_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (gray_queue.size() == 0) begin
            $error("unexpected transaction: brightness %0d last_res %0d",
                   got.brightness, got.last_res);
            failures++;
         end else begin
            want = gray_queue.pop_front();
            if (got.brightness !== want.brightness) begin
               $error("brightness: expected %0d, actual %0d", want.brightness, got.brightness);
               failures++;
            end
            if (got.last_res !== want.last_res) begin
               $error("last_res: expected %0d, actual %0d", want.last_res, got.last_res);
               failures++;
            end
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_HISTOGRAM_MODE) mode_shadow = value[0];
      else bp_shadow = value[BP_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send(logic func, logic [DEPTH_W-1:0] depth, logic last);
      pixel_type p;
      p.func  = func;
      p.depth = depth;
      p.last  = last;
      pixel_queue.push_back(p);
   endtask

   // drain results, then let the clear walk finish
   task automatic settle();
      while (pixel_queue.size() > 0 || gray_queue.size() > 0) @(posedge clock);
      repeat (LEVELS + 300) @(posedge clock);
   endtask

   function automatic logic [DEPTH_W-1:0] pick_depth(logic [BP_W-1:0] bp);
      int r;
      r = $urandom_range(99);
      if (r < 8) return '0;
      if (r < 60) return DEPTH_W'($urandom_range(bp == 0 ? 1 : bp, 1));
      if (r < 70) return DEPTH_W'(DEPTH_W'(bp) + DEPTH_W'($urandom_range(2)) - 1);
      if (r < 80) return DEPTH_W'($urandom_range(65535, LEVELS - 2));
      return DEPTH_W'($urandom_range(65535));
   endfunction

   initial begin
      logic [BP_W-1:0] bp;
      int n;
      failures       = 0;
      idle_mode      = 2;
      long_stall_req = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_HISTOGRAM_MODE;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      rsp_if.ready   = 1'b0;
      mode_shadow    = 1'b0;
      bp_shadow      = 14'd4000;
      clear_hist();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (LEVELS + 300) @(posedge clock);

      // linear mode at reset settings
      send(1, 0, 0); send(1, 1, 0); send(1, 3999, 0); send(1, 4000, 0);
      send(1, 4001, 0); send(1, 65535, 0); send(1, 16384, 0); send(1, 2000, 0);
      send(0, 100, 1); send(1, 1000, 1);
      settle();
      write_csr(CSR_BACKPLANE, 0);
      send(1, 5, 0); send(1, 0, 0); send(1, 65535, 1);
      settle();
      // histogram mode
      write_csr(CSR_BACKPLANE, 16383);
      write_csr(CSR_HISTOGRAM_MODE, 1);
      send(1, 50, 0);
      send(0, 0, 0); send(0, 1, 0); send(0, 1, 0); send(0, 16383, 0);
      send(0, 16384, 0); send(0, 65535, 0); send(0, 8000, 0); send(0, 500, 1);
      send(1, 0, 0); send(1, 1, 0); send(1, 2, 0); send(1, 16383, 0);
      send(1, 16384, 0); send(1, 500, 0); send(1, 8000, 0); send(1, 65535, 0);
      send(0, 7, 0); send(1, 1, 0); send(1, 500, 1);
      settle();

      for (int ph = 0; ph < 10; ph++) begin
         idle_mode = (ph < 3) ? 0 : (ph < 6) ? 1 : 2;
         if (ph == 4) begin
            bp = BP_W'($urandom_range(16383, 200));
            write_csr(CSR_BACKPLANE, bp);
            write_csr(CSR_HISTOGRAM_MODE, 1);
            for (int i = 0; i < 250; i++) send(0, pick_depth(bp), i == 249);
            while (pixel_queue.size() > 0) @(posedge clock);
            for (int i = 0; i < 250; i++) send(1, pick_depth(bp), i == 249);
            while (!rsp_if.valid) @(posedge clock);
            long_stall_req <= 1'b1;
            @(posedge clock);
            @(posedge clock);
            long_stall_req <= 1'b0;
         end else begin
            case (ph)
               0: bp = 14'd16383;
               1: bp = 14'd1;
               default: bp = BP_W'($urandom_range(16383, 1));
            endcase
            write_csr(CSR_HISTOGRAM_MODE, 0);
            write_csr(CSR_BACKPLANE, bp);
            n = 110;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(9) == 0) send(0, pick_depth(bp), $urandom_range(1));
               else send(1, pick_depth(bp), i == n - 1 || $urandom_range(99) == 0);
            end
         end
         settle();
      end

      while (pixel_queue.size() > 0 || gray_queue.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (gray_queue.size() != 0) failures++;
      if (failures == 0) begin
         $display("PASS depth_to_gray_histogram_map");
      end else begin
         $display("FAIL depth_to_gray_histogram_map");
      end
      $finish;
   end
endmodule
